// ===== rtl/core/thp_pkg.sv =====
// types, constants and stage functions for the sensor compensation pipeline
`default_nettype none
package thp_pkg;

    localparam int NUM_PRE  = 14;
    localparam int NUM_DIV  = 32;
    localparam int NUM_POST = 3;
    localparam int NUM_STG  = NUM_PRE + NUM_DIV + NUM_POST;

    localparam logic [2:0] REG_TEMP       = 3'd0;
    localparam logic [2:0] REG_PRESS_LOW  = 3'd1;
    localparam logic [2:0] REG_PRESS_HIGH = 3'd2;
    localparam logic [2:0] REG_PRESS_NINE = 3'd3;
    localparam logic [2:0] REG_HUM        = 3'd4;
    localparam logic [2:0] REG_HUM_SIX    = 3'd5;

    localparam logic [31:0] HUM_MAX = 32'd419430400;

    typedef struct packed {
        logic [31:0] t1, t2, t3;
        logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] h1, h2, h3, h4, h5, h6;
    } t_coef;

    typedef struct packed {
        logic [19:0] adc_t;
        logic [19:0] adc_p;
        logic [15:0] adc_h;
        logic [31:0] fine;
        logic [31:0] temp;
        logic [31:0] pa, pb, pc, pd;
        logic [31:0] hx, hy, hz, hw;
        logic [31:0] num;
        logic [31:0] rem;
        logic [31:0] den;
        logic        dbl;
        logic        inval;
        logic [16:0] hum;
    } t_pipe;

    function automatic logic [31:0] asr(input logic [31:0] x, input int n);
        asr = 32'($signed(x) >>> n);
    endfunction

    function automatic logic [31:0] mul(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = a * b;
        mul = p[31:0];
    endfunction

    function automatic t_pipe step(input int k, input t_pipe s, input t_coef c);
        t_pipe       n;
        logic [32:0] tr;
        logic [31:0] v;
        logic [31:0] p;
        n  = s;
        tr = '0;
        v  = '0;
        p  = '0;
        if (k >= NUM_PRE && k < NUM_PRE + NUM_DIV) begin
            tr = {s.rem, s.num[31]};
            if (tr >= {1'b0, s.den}) begin
                tr    = tr - {1'b0, s.den};
                n.num = {s.num[30:0], 1'b1};
            end else begin
                n.num = {s.num[30:0], 1'b0};
            end
            n.rem = tr[31:0];
        end else begin
            case (k)
                0: begin
                    n.pa = {15'd0, s.adc_t[19:3]} - {c.t1[30:0], 1'b0};
                    n.pb = {16'd0, s.adc_t[19:4]} - c.t1;
                end
                1: begin
                    n.pa = mul(s.pa, c.t2);
                    n.pb = mul(s.pb, s.pb);
                end
                2: begin
                    n.pa = asr(s.pa, 11);
                    n.pb = mul(asr(s.pb, 12), c.t3);
                end
                3: n.fine = s.pa + asr(s.pb, 14);
                4: begin
                    n.temp = asr({s.fine[29:0], 2'b00} + s.fine + 32'd128, 8);
                    n.pa   = asr(s.fine, 1) - 32'd64000;
                    n.hw   = s.fine - 32'd76800;
                end
                5: begin
                    n.pb = mul(asr(s.pa, 2), asr(s.pa, 2));
                    n.pc = mul(s.pa, c.p5);
                    n.pd = mul(c.p2, s.pa);
                    n.hx = mul(c.h5, s.hw);
                    n.hy = mul(s.hw, c.h6);
                    n.hz = mul(s.hw, c.h3);
                end
                6: begin
                    n.pb = mul(asr(s.pb, 11), c.p6) + {s.pc[30:0], 1'b0};
                    n.pc = mul(c.p3, asr(s.pb, 13));
                    n.hx = asr({2'b00, s.adc_h, 14'd0} - {c.h4[11:0], 20'd0} - s.hx
                               + 32'd16384, 15);
                    n.hy = asr(s.hy, 10);
                    n.hz = asr(s.hz, 11) + 32'd32768;
                end
                7: begin
                    n.pb = asr(asr(s.pb, 2) + {c.p4[15:0], 16'd0}, 12);
                    n.pa = asr(asr(s.pc, 3) + asr(s.pd, 1), 18);
                    n.hy = asr(mul(s.hy, s.hz), 10) + 32'd2097152;
                end
                8: begin
                    n.pa = mul(32'd32768 + s.pa, c.p1);
                    n.pb = mul(32'd1048576 - {12'd0, s.adc_p} - s.pb, 32'd3125);
                    n.hy = mul(s.hy, c.h2) + 32'd8192;
                end
                9: begin
                    n.den   = asr(s.pa, 15);
                    n.inval = (asr(s.pa, 15) == 32'd0);
                    n.rem   = '0;
                    if (!s.pb[31]) begin
                        n.num = {s.pb[30:0], 1'b0};
                        n.dbl = 1'b0;
                    end else begin
                        n.num = s.pb;
                        n.dbl = 1'b1;
                    end
                    n.hz = asr(s.hy, 14);
                end
                10: n.hw = mul(s.hx, s.hz);
                11: n.hx = mul(asr(s.hw, 15), asr(s.hw, 15));
                12: n.hx = mul(asr(s.hx, 7), c.h1);
                13: begin
                    v = s.hw - asr(s.hx, 4);
                    if (v[31]) v = '0;
                    if (v > HUM_MAX) v = HUM_MAX;
                    n.hum = v[28:12];
                end
                NUM_PRE + NUM_DIV: begin
                    p    = s.dbl ? {s.num[30:0], 1'b0} : s.num;
                    n.pa = p;
                    n.pb = mul({3'd0, p[31:3]}, {3'd0, p[31:3]});
                    n.pc = mul({2'd0, p[31:2]}, c.p8);
                end
                NUM_PRE + NUM_DIV + 1: begin
                    n.pb = asr(mul(c.p9, {13'd0, s.pb[31:13]}), 12);
                    n.pc = asr(s.pc, 13);
                end
                NUM_PRE + NUM_DIV + 2: begin
                    n.pd = s.inval ? 32'd0 : s.pa + asr(s.pb + s.pc + c.p7, 4);
                end
                default: n = s;
            endcase
        end
        step = n;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/thp_sensor_compensation_unit.sv =====
// top level of the temperature, pressure and humidity compensation pipeline
`default_nettype none
// Fully pipelined 32-bit integer compensation: one reading per cycle. The pipeline has 49
// register stages; the first one loads at the accepting edge and the last one is the output
// register. Fourteen stages compute temperature, humidity and the pressure operands, a
// 32-stage restoring divider (one quotient bit per stage) produces the pressure quotient,
// and three stages finish the pressure. The whole pipeline holds while the output register
// is full and not taken. The user must write the coefficients through the plain write port
// only while the block is idle; the block itself does not enforce this.
module thp_sensor_compensation_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // raw_temperature[19:0], raw_pressure[39:20], raw_humidity[55:40]
    input  wire logic [55:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // temperature_centi[31:0], pressure_pa[63:32], humidity_q10[80:64]
    output logic [87:0]      m_axis_tdata,
    // pressure_invalid[0]
    output logic             m_axis_tuser
);

    localparam int NS = thp_pkg::NUM_STG;

    logic [47:0] r_temp_coeffs;
    logic [63:0] r_press_low;
    logic [63:0] r_press_high;
    logic [15:0] r_press_nine;
    logic [63:0] r_hum_coeffs;
    logic [7:0]  r_hum_six;

    thp_pkg::t_coef coef;
    thp_pkg::t_pipe in_item;
    thp_pkg::t_pipe r_st [NS];
    thp_pkg::t_pipe n_st [NS];
    logic [NS-1:0]  r_vld;
    logic           adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_coeffs <= '0;
            r_press_low   <= '0;
            r_press_high  <= '0;
            r_press_nine  <= '0;
            r_hum_coeffs  <= '0;
            r_hum_six     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                thp_pkg::REG_TEMP:       r_temp_coeffs <= i_cfg_wdata[47:0];
                thp_pkg::REG_PRESS_LOW:  r_press_low   <= i_cfg_wdata;
                thp_pkg::REG_PRESS_HIGH: r_press_high  <= i_cfg_wdata;
                thp_pkg::REG_PRESS_NINE: r_press_nine  <= i_cfg_wdata[15:0];
                thp_pkg::REG_HUM:        r_hum_coeffs  <= i_cfg_wdata;
                thp_pkg::REG_HUM_SIX:    r_hum_six     <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        coef.t1 = {16'd0, r_temp_coeffs[15:0]};
        coef.t2 = {{16{r_temp_coeffs[31]}}, r_temp_coeffs[31:16]};
        coef.t3 = {{16{r_temp_coeffs[47]}}, r_temp_coeffs[47:32]};
        coef.p1 = {16'd0, r_press_low[15:0]};
        coef.p2 = {{16{r_press_low[31]}}, r_press_low[31:16]};
        coef.p3 = {{16{r_press_low[47]}}, r_press_low[47:32]};
        coef.p4 = {{16{r_press_low[63]}}, r_press_low[63:48]};
        coef.p5 = {{16{r_press_high[15]}}, r_press_high[15:0]};
        coef.p6 = {{16{r_press_high[31]}}, r_press_high[31:16]};
        coef.p7 = {{16{r_press_high[47]}}, r_press_high[47:32]};
        coef.p8 = {{16{r_press_high[63]}}, r_press_high[63:48]};
        coef.p9 = {{16{r_press_nine[15]}}, r_press_nine};
        coef.h1 = {24'd0, r_hum_coeffs[7:0]};
        coef.h2 = {{16{r_hum_coeffs[23]}}, r_hum_coeffs[23:8]};
        coef.h3 = {24'd0, r_hum_coeffs[31:24]};
        coef.h4 = {{16{r_hum_coeffs[47]}}, r_hum_coeffs[47:32]};
        coef.h5 = {{16{r_hum_coeffs[63]}}, r_hum_coeffs[63:48]};
        coef.h6 = {{24{r_hum_six[7]}}, r_hum_six};
    end

    always_comb begin
        in_item       = '0;
        in_item.adc_t = s_axis_tdata[19:0];
        in_item.adc_p = s_axis_tdata[39:20];
        in_item.adc_h = s_axis_tdata[55:40];
    end

    assign adv           = !r_vld[NS-1] || m_axis_tready;
    assign s_axis_tready = adv;

    for (genvar g = 0; g < NS; g++) begin : g_stage
        if (g == 0) begin : g_first
            always_comb n_st[g] = thp_pkg::step(g, in_item, coef);
        end else begin : g_rest
            always_comb n_st[g] = thp_pkg::step(g, r_st[g-1], coef);
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_st[g] <= n_st[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NS-2:0], s_axis_tvalid};
        end
    end

    assign m_axis_tvalid = r_vld[NS-1];
    assign m_axis_tdata  = {7'd0, r_st[NS-1].hum, r_st[NS-1].pd, r_st[NS-1].temp};
    assign m_axis_tuser  = r_st[NS-1].inval;

endmodule
`default_nettype wire
